// ===== design/cartridge_bank_mapper_irq_unit_defines.svh =====
// Assertion macros shared by the cartridge bank mapper design files.
// Depends on nothing; included by the files that carry concurrent checks.
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_UNIT_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held low.
`define CBM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held low.
`define CBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cbm_pkg.sv =====
// Types and constants for the cartridge bank mapper with IRQ counter.
// No dependencies; used by every module of the block.
package cbm_pkg;

    // Transaction kinds on the input channel
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_PPU   = 2'd2,
        MODE_TICK  = 2'd3
    } t_mode;

    // Memory targets reported in each result
    typedef enum logic [2:0] {
        TGT_NONE  = 3'd0,
        TGT_REG   = 3'd1,
        TGT_RAM   = 3'd2,
        TGT_ROM   = 3'd3,
        TGT_CHR   = 3'd4,
        TGT_CIRAM = 3'd5
    } t_target;

    // Configuration register indexes
    localparam logic CFG_PRG_ROM_BANKS   = 1'b0;
    localparam logic CFG_PRG_RAM_PRESENT = 1'b1;

    // 2KB register pages, by address bits 15:11
    localparam logic [4:0] PAGE_CNT_LO = 5'h0A;
    localparam logic [4:0] PAGE_CNT_HI = 5'h0B;
    localparam logic [4:0] PAGE_PRG0   = 5'h1C;
    localparam logic [4:0] PAGE_PRG1   = 5'h1D;
    localparam logic [4:0] PAGE_PRG2   = 5'h1E;

    localparam logic [15:0] REG_SPACE_MIN = 16'h4800;
    localparam logic [14:0] IRQ_STOP      = 15'h7FFE;
    localparam logic [7:0]  CIRAM_MIN     = 8'hE0;
    localparam logic [6:0]  ROM_BANKS_RST = 7'd64;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        t_target     target;
        logic [7:0]  bank;
        logic [12:0] offset;
        logic [7:0]  read_data;
        logic        irq_line;
    } t_out_item;

endpackage

// ===== design/cbm_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct per transaction.
// Payload type is a parameter; the block uses cbm_pkg::t_in_item and t_out_item.
interface cbm_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/cartridge_bank_mapper_irq_unit.sv =====
// Cartridge bank mapper with CPU-cycle IRQ counter: top level.
// Input stream carries CPU writes, CPU reads, PPU fetches to translate and
// CPU-cycle ticks; output stream carries one result per input transaction:
// target memory, bank, offset, counter read byte and the IRQ level after it.
// Configuration port: i_cfg_we writes i_cfg_wdata into register i_cfg_index
// (0 PRG ROM bank count, 1 PRG RAM present); write only while idle.
// Path: an accepted transaction is captured in the input register, then
// decoded with the state update into the result register. Throughput:
// one transaction per cycle while the receiver holds ready high, set by
// the single decode pass between the two registers.
// Stall: when the receiver holds ready low the result register holds its
// transaction, the input register fills, and then input ready drops; no
// transaction is lost or repeated.
// Reset (synchronous, active low): bank, nametable and counter state clear to
// zero, PRG ROM bank count returns to 64, PRG RAM present to 1, both
// channels empty. No clearing pass is needed.
// Depends on cbm_pkg, cbm_stream_if, cbm_in_stage, cbm_core, cbm_out_stage.
module cartridge_bank_mapper_irq_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cbm_stream_if.sink   i_in,
    cbm_stream_if.source o_out,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [6:0]   i_cfg_wdata
);
    logic               in_valid;
    cbm_pkg::t_in_item  in_item;
    logic               out_can_load;
    logic               step;
    cbm_pkg::t_out_item result;

    // Move a held transaction on when the result register has room
    assign step = in_valid && out_can_load;

    cbm_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (out_can_load),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    cbm_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (result)
    );

    cbm_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_valid),
        .i_result   (result),
        .o_can_load (out_can_load),
        .o_out      (o_out)
    );
endmodule

// ===== design/cbm_in_stage.sv =====
// Input register of the mapper: captures one transaction from the sink channel.
// Depends on cbm_pkg and cbm_stream_if.
module cbm_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cbm_stream_if.sink        i_in,
    input  logic              i_take,
    output logic              o_valid,
    output cbm_pkg::t_in_item o_item
);
    logic              r_valid;
    cbm_pkg::t_in_item r_item;

    // Accept when empty or when the held transaction moves on this cycle
    assign i_in.ready = !r_valid || i_take;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // Hold the payload until it is taken
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= i_in.payload;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// ===== design/cbm_core.sv =====
// Mapper state and per-transaction logic: bank registers, IRQ counter, decode.
// Depends on cbm_pkg and the assertion macros header.
`include "cartridge_bank_mapper_irq_unit_defines.svh"

module cbm_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  cbm_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [6:0]         i_cfg_wdata,
    output cbm_pkg::t_out_item o_result
);
    localparam logic [7:0] CIRAM_MIN_L = cbm_pkg::CIRAM_MIN;

    logic [6:0]  r_rom_banks;
    logic        r_ram_present;
    logic [5:0]  r_prg_bank [0:2];
    logic [5:0]  n_prg_bank [0:2];
    logic [7:0]  r_pat_bank [0:7];
    logic [7:0]  n_pat_bank [0:7];
    logic [7:0]  r_nt_bank  [0:3];
    logic [7:0]  n_nt_bank  [0:3];
    logic [1:0]  r_ciram_dis;
    logic [1:0]  n_ciram_dis;
    logic [14:0] r_irq_count;
    logic [14:0] n_irq_count;
    logic        r_irq_enabled;
    logic        n_irq_enabled;
    logic        r_irq_asserted;
    logic        n_irq_asserted;

    logic [15:0] addr;
    logic [4:0]  page;
    logic [2:0]  slot;
    logic [7:0]  ppu_val;
    logic        ppu_ciram;
    logic [7:0]  fixed_bank;
    logic [7:0]  rom_bank;
    logic [14:0] cnt_inc;

    assign addr    = i_item.address;
    assign page    = addr[15:11];
    assign slot    = addr[12:10];
    assign cnt_inc = r_irq_count + 15'd1;

    // Fixed top bank: last ROM bank, an empty ROM counts as one bank
    assign fixed_bank = (r_rom_banks == 7'd0) ? 8'd0 : {1'b0, r_rom_banks - 7'd1};

    // Switchable PRG bank for 0x8000-0xDFFF, fixed bank above
    always_comb begin
        unique case (addr[14:13])
            2'b00:   rom_bank = {2'b00, r_prg_bank[0]};
            2'b01:   rom_bank = {2'b00, r_prg_bank[1]};
            2'b10:   rom_bank = {2'b00, r_prg_bank[2]};
            default: rom_bank = fixed_bank;
        endcase
    end

    // Pattern or nametable lookup for PPU fetches
    always_comb begin
        if (!addr[13]) begin
            ppu_val   = r_pat_bank[slot];
            ppu_ciram = (ppu_val >= CIRAM_MIN_L) && !r_ciram_dis[slot[2]];
        end else begin
            ppu_val   = r_nt_bank[addr[11:10]];
            ppu_ciram = ppu_val >= CIRAM_MIN_L;
        end
    end

    // Decode the transaction and work out the next state
    always_comb begin
        n_prg_bank     = r_prg_bank;
        n_pat_bank     = r_pat_bank;
        n_nt_bank      = r_nt_bank;
        n_ciram_dis    = r_ciram_dis;
        n_irq_count    = r_irq_count;
        n_irq_enabled  = r_irq_enabled;
        n_irq_asserted = r_irq_asserted;
        o_result       = '0;
        o_result.target = cbm_pkg::TGT_NONE;

        unique case (i_item.mode)
            cbm_pkg::MODE_WRITE: begin
                if (addr[15:13] == 3'b011) begin
                    if (r_ram_present) begin
                        o_result.target = cbm_pkg::TGT_RAM;
                        o_result.offset = addr[12:0];
                    end
                end else if (addr >= cbm_pkg::REG_SPACE_MIN) begin
                    o_result.target = cbm_pkg::TGT_REG;
                    unique case (page)
                        cbm_pkg::PAGE_CNT_LO: begin
                            n_irq_count    = {r_irq_count[14:8], i_item.write_data};
                            n_irq_asserted = 1'b0;
                        end
                        cbm_pkg::PAGE_CNT_HI: begin
                            n_irq_enabled  = i_item.write_data[7];
                            n_irq_count    = {i_item.write_data[6:0], r_irq_count[7:0]};
                            n_irq_asserted = 1'b0;
                        end
                        cbm_pkg::PAGE_PRG0: begin
                            n_prg_bank[0] = i_item.write_data[5:0];
                        end
                        cbm_pkg::PAGE_PRG1: begin
                            n_prg_bank[1] = i_item.write_data[5:0];
                            n_ciram_dis   = i_item.write_data[7:6];
                        end
                        cbm_pkg::PAGE_PRG2: begin
                            n_prg_bank[2] = i_item.write_data[5:0];
                        end
                        default: begin
                            if (addr[15:14] == 2'b10) begin
                                n_pat_bank[addr[13:11]] = i_item.write_data;
                            end else if (addr[15:13] == 3'b110) begin
                                n_nt_bank[addr[12:11]] = i_item.write_data;
                            end
                        end
                    endcase
                end
            end
            cbm_pkg::MODE_READ: begin
                if (addr[15]) begin
                    o_result.target = cbm_pkg::TGT_ROM;
                    o_result.bank   = rom_bank;
                    o_result.offset = addr[12:0];
                end else if (addr[14:13] == 2'b11) begin
                    if (r_ram_present) begin
                        o_result.target = cbm_pkg::TGT_RAM;
                        o_result.offset = addr[12:0];
                    end
                end else if (page == cbm_pkg::PAGE_CNT_LO) begin
                    o_result.target    = cbm_pkg::TGT_REG;
                    o_result.read_data = r_irq_count[7:0];
                end else if (page == cbm_pkg::PAGE_CNT_HI) begin
                    o_result.target    = cbm_pkg::TGT_REG;
                    o_result.read_data = {1'b0, r_irq_count[14:8]};
                end
            end
            cbm_pkg::MODE_PPU: begin
                o_result.target = ppu_ciram ? cbm_pkg::TGT_CIRAM : cbm_pkg::TGT_CHR;
                o_result.bank   = ppu_ciram ? {7'd0, ppu_val[0]} : ppu_val;
                o_result.offset = {3'd0, addr[9:0]};
            end
            cbm_pkg::MODE_TICK: begin
                // Advance the counter; stop and raise the IRQ at the terminal value
                if (r_irq_enabled) begin
                    n_irq_count = cnt_inc;
                    if (cnt_inc == cbm_pkg::IRQ_STOP) begin
                        n_irq_asserted = 1'b1;
                        n_irq_enabled  = 1'b0;
                    end
                end
            end
            default: begin
                o_result.target = cbm_pkg::TGT_NONE;
            end
        endcase

        o_result.irq_line = n_irq_asserted;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_banks   <= cbm_pkg::ROM_BANKS_RST;
            r_ram_present <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cbm_pkg::CFG_PRG_ROM_BANKS:   r_rom_banks   <= i_cfg_wdata;
                cbm_pkg::CFG_PRG_RAM_PRESENT: r_ram_present <= i_cfg_wdata[0];
                default:                      r_ram_present <= r_ram_present;
            endcase
        end
    end

    // Mapper state: commit only when a transaction moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank     <= '{default: '0};
            r_pat_bank     <= '{default: '0};
            r_nt_bank      <= '{default: '0};
            r_ciram_dis    <= '0;
            r_irq_count    <= '0;
            r_irq_enabled  <= 1'b0;
            r_irq_asserted <= 1'b0;
        end else if (i_step) begin
            r_prg_bank     <= n_prg_bank;
            r_pat_bank     <= n_pat_bank;
            r_nt_bank      <= n_nt_bank;
            r_ciram_dis    <= n_ciram_dis;
            r_irq_count    <= n_irq_count;
            r_irq_enabled  <= n_irq_enabled;
            r_irq_asserted <= n_irq_asserted;
        end
    end

    `CBM_ASSERT_IMPL(a_irq_rise_at_stop, i_clk, i_rst_n, $rose(r_irq_asserted),
        (r_irq_count == cbm_pkg::IRQ_STOP) && !r_irq_enabled,
        "IRQ raised away from terminal count")
    `CBM_ASSERT_IMPL(a_irq_excl, i_clk, i_rst_n, 1'b1,
        !(r_irq_enabled && r_irq_asserted), "IRQ pending while counter enabled")
    `CBM_ASSERT_NEXT(a_hold_no_step, i_clk, i_rst_n, !i_step,
        $stable(r_irq_count) && $stable(r_irq_enabled) && $stable(r_irq_asserted),
        "counter state moved without a transaction")
endmodule

// ===== design/cbm_out_stage.sv =====
// Result register of the mapper: drives the source channel, holds under stall.
// Depends on cbm_pkg and cbm_stream_if.
module cbm_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  cbm_pkg::t_out_item i_result,
    output logic               o_can_load,
    cbm_stream_if.source       o_out
);
    logic               r_valid;
    cbm_pkg::t_out_item r_result;

    // Free when empty or when the receiver takes the current transaction
    assign o_can_load = !r_valid || o_out.ready;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Capture a new result
    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid   = r_valid;
    assign o_out.payload = r_result;
endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for cartridge_bank_mapper_irq_unit: CPU writes, reads, PPU fetches, ticks.
// Compares every result against the typed table value or an in-bench translation and IRQ counter model.
// Depends on cbm_pkg, cbm_stream_if and cartridge_bank_mapper_irq_unit from the design folder.
module tb_top;
    import cbm_pkg::*;

    localparam int ITEMS_PER_PHASE = 320;
    localparam int PHASE_COUNT     = 5;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DIRECTED_COUNT  = 29;

    typedef struct {
        t_in_item  access;
        bit        typed;
        t_out_item result;
    } t_directed_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [6:0] cfg_wdata;

    // Expected result typed into the stimulus table, carried alongside the payload
    logic      typed_valid;
    t_out_item typed_result;

    cbm_stream_if #(.T(t_in_item))  access_ch ();
    cbm_stream_if #(.T(t_out_item)) result_ch ();

    cartridge_bank_mapper_irq_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (access_ch),
        .o_out       (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // Mapper state as the bench expects it
    logic [6:0]  rom_banks        = ROM_BANKS_RST;
    logic        ram_present      = 1'b1;
    logic [5:0]  prg_bank [3]     = '{default: '0};
    logic [7:0]  pattern_bank [8] = '{default: '0};
    logic [7:0]  nametable_bank [4] = '{default: '0};
    logic [1:0]  ciram_disable    = '0;
    logic [14:0] irq_count        = '0;
    logic        irq_enable       = 1'b0;
    logic        irq_pending      = 1'b0;

    t_out_item pending_translations [$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    int        stall_left     = 0;
    int        source_idle_pct = 30;
    int        sink_idle_pct   = 30;

    // Directed transactions: reset state, address extremes, CIRAM selection, IRQ and wrap
    t_directed_row directed_rows [DIRECTED_COUNT] = '{
        '{'{MODE_TICK,  16'h0000, 8'h00}, 1'b1, '{TGT_NONE,  8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_READ,  16'h5000, 8'h00}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_READ,  16'hE000, 8'h00}, 1'b1, '{TGT_ROM,   8'h3F, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_READ,  16'hFFFF, 8'h00}, 1'b1, '{TGT_ROM,   8'h3F, 13'h1FFF, 8'h00, 1'b0}},
        '{'{MODE_READ,  16'h6000, 8'h00}, 1'b1, '{TGT_RAM,   8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_WRITE, 16'h47FF, 8'hFF}, 1'b1, '{TGT_NONE,  8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_WRITE, 16'h4800, 8'hFF}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_WRITE, 16'hFFFF, 8'hFF}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_WRITE, 16'h7123, 8'hAA}, 1'b1, '{TGT_RAM,   8'h00, 13'h1123, 8'h00, 1'b0}},
        '{'{MODE_PPU,   16'h0000, 8'h00}, 1'b1, '{TGT_CHR,   8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_PPU,   16'hFFFF, 8'h00}, 1'b1, '{TGT_CHR,   8'h00, 13'h03FF, 8'h00, 1'b0}},
        '{'{MODE_WRITE, 16'h8000, 8'hFF}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_PPU,   16'h0000, 8'h00}, 1'b1, '{TGT_CIRAM, 8'h01, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_WRITE, 16'hE800, 8'hFF}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_PPU,   16'h03FF, 8'h00}, 1'b1, '{TGT_CHR,   8'hFF, 13'h03FF, 8'h00, 1'b0}},
        '{'{MODE_READ,  16'hA000, 8'h00}, 1'b1, '{TGT_ROM,   8'h3F, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_WRITE, 16'hC000, 8'hE0}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_PPU,   16'h2000, 8'h00}, 1'b1, '{TGT_CIRAM, 8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_WRITE, 16'hD800, 8'hE1}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_PPU,   16'h3C00, 8'h00}, 1'b0, '{TGT_NONE,  8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_WRITE, 16'h5000, 8'hFD}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_WRITE, 16'h5800, 8'hFF}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_READ,  16'h5800, 8'h00}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'h7F, 1'b0}},
        '{'{MODE_TICK,  16'h0000, 8'h00}, 1'b1, '{TGT_NONE,  8'h00, 13'h0000, 8'h00, 1'b1}},
        '{'{MODE_READ,  16'h5000, 8'h00}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'hFE, 1'b1}},
        '{'{MODE_WRITE, 16'h5000, 8'hFF}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_WRITE, 16'h5800, 8'hFF}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_TICK,  16'h0000, 8'h00}, 1'b1, '{TGT_NONE,  8'h00, 13'h0000, 8'h00, 1'b0}},
        '{'{MODE_READ,  16'h5000, 8'h00}, 1'b1, '{TGT_REG,   8'h00, 13'h0000, 8'h00, 1'b0}}
    };

    // Clock: period 10
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Translate one transaction and advance the mapper state
    function automatic t_out_item translate_access(input t_in_item acc);
        t_out_item   res;
        logic [13:0] ppu_addr;
        logic [2:0]  slot;
        logic [7:0]  sel;
        logic        use_ciram;
        res = '0;
        case (acc.mode)
            MODE_WRITE: begin
                if (acc.address >= 16'h6000 && acc.address < 16'h8000) begin
                    if (ram_present) begin
                        res.target = TGT_RAM;
                        res.offset = acc.address[12:0];
                    end
                end else if (acc.address >= REG_SPACE_MIN) begin
                    res.target = TGT_REG;
                    case (acc.address[15:11])
                        PAGE_CNT_LO: begin
                            irq_count[7:0] = acc.write_data;
                            irq_pending    = 1'b0;
                        end
                        PAGE_CNT_HI: begin
                            irq_enable      = acc.write_data[7];
                            irq_count[14:8] = acc.write_data[6:0];
                            irq_pending     = 1'b0;
                        end
                        PAGE_PRG0: prg_bank[0] = acc.write_data[5:0];
                        PAGE_PRG1: begin
                            prg_bank[1]   = acc.write_data[5:0];
                            ciram_disable = acc.write_data[7:6];
                        end
                        PAGE_PRG2: prg_bank[2] = acc.write_data[5:0];
                        default: begin
                            // Pattern banks at 0x8000-0xBFFF, nametables at 0xC000-0xDFFF
                            if (acc.address[15:14] == 2'b10) begin
                                pattern_bank[acc.address[13:11]] = acc.write_data;
                            end else if (acc.address[15:13] == 3'b110) begin
                                nametable_bank[acc.address[12:11]] = acc.write_data;
                            end
                        end
                    endcase
                end
            end
            MODE_READ: begin
                if (acc.address >= 16'h8000) begin
                    res.target = TGT_ROM;
                    res.offset = acc.address[12:0];
                    if (acc.address >= 16'hE000) begin
                        // A bank count of zero still maps bank 0 at the top
                        res.bank = (rom_banks == 7'd0) ? 8'd0 : {1'b0, rom_banks - 7'd1};
                    end else begin
                        res.bank = {2'b00, prg_bank[acc.address[14:13]]};
                    end
                end else if (acc.address >= 16'h6000) begin
                    if (ram_present) begin
                        res.target = TGT_RAM;
                        res.offset = acc.address[12:0];
                    end
                end else if (acc.address[15:11] == PAGE_CNT_LO) begin
                    res.target    = TGT_REG;
                    res.read_data = irq_count[7:0];
                end else if (acc.address[15:11] == PAGE_CNT_HI) begin
                    res.target    = TGT_REG;
                    res.read_data = {1'b0, irq_count[14:8]};
                end
            end
            MODE_PPU: begin
                ppu_addr = acc.address[13:0];
                if (ppu_addr < 14'h2000) begin
                    slot      = ppu_addr[12:10];
                    sel       = pattern_bank[slot];
                    use_ciram = sel >= CIRAM_MIN && !ciram_disable[slot[2]];
                end else begin
                    sel       = nametable_bank[ppu_addr[11:10]];
                    use_ciram = sel >= CIRAM_MIN;
                end
                res.target = use_ciram ? TGT_CIRAM : TGT_CHR;
                res.bank   = use_ciram ? {7'd0, sel[0]} : sel;
                res.offset = {3'b000, ppu_addr[9:0]};
            end
            default: begin
                if (irq_enable) begin
                    irq_count = irq_count + 15'd1;
                    if (irq_count == IRQ_STOP) begin
                        irq_pending = 1'b1;
                        irq_enable  = 1'b0;
                    end
                end
            end
        endcase
        res.irq_line = irq_pending;
        return res;
    endfunction

    // Idle length: mostly none, short gaps often, long ones rarely
    function automatic int gap_len(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic t_in_item random_access();
        t_in_item   acc;
        int         pick;
        logic [4:0] page;
        acc.address    = 16'($urandom);
        acc.write_data = 8'($urandom);
        acc.mode       = MODE_TICK;
        pick           = $urandom_range(99);
        if (pick < 35) begin
            acc.mode = MODE_WRITE;
            // Aim most writes at register pages, with values that hit CIRAM and IRQ
            if ($urandom_range(3) != 0) begin
                page = 5'($urandom_range(31, 9));
                acc.address[15:11] = page;
                if (page == PAGE_CNT_LO && $urandom_range(1) == 1) begin
                    acc.write_data = 8'($urandom_range(255, 240));
                end else if (page == PAGE_CNT_HI && $urandom_range(1) == 1) begin
                    acc.write_data = 8'hFF;
                end else if (page >= 5'h10 && page < PAGE_PRG0 && $urandom_range(1) == 1) begin
                    acc.write_data[7:5] = 3'b111;
                end
            end
        end else if (pick < 55) begin
            acc.mode = MODE_READ;
            if ($urandom_range(1) == 1) acc.address[15:11] = 5'($urandom_range(31, 10));
        end else if (pick < 75) begin
            acc.mode = MODE_PPU;
            if ($urandom_range(4) != 0) acc.address[15:14] = 2'b00;
        end
        return acc;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Offer one transaction and hold it until accepted, then idle at random
    task automatic send_access(input t_in_item acc, input bit typed, input t_out_item res);
        int gap;
        access_ch.valid   <= 1'b1;
        access_ch.payload <= acc;
        typed_valid       <= typed;
        typed_result      <= res;
        do @(posedge i_clk); while (!access_ch.ready);
        gap = gap_len(source_idle_pct);
        if (gap > 0) begin
            access_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and wait for every outstanding result, then idle for SETTLE_CYCLES
    task automatic settle();
        access_ch.valid <= 1'b0;
        // Let the last accepted transaction reach the expected queue first
        @(posedge i_clk);
        while (pending_translations.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write both configuration registers on back-to-back edges
    task automatic load_config(input logic [6:0] banks, input logic present);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PRG_ROM_BANKS;
        cfg_wdata <= banks;
        @(posedge i_clk);
        cfg_index <= CFG_PRG_RAM_PRESENT;
        cfg_wdata <= {6'd0, present};
        @(posedge i_clk);
        cfg_we      <= 1'b0;
        rom_banks   = banks;
        ram_present = present;
    endtask

    // Load the counter just short of the stop value and tick through it
    task automatic run_irq_countdown(inout int sent);
        t_in_item acc;
        int       ticks;
        logic [7:0] low_byte;
        low_byte = 8'($urandom_range(253, 224));
        acc      = '{MODE_WRITE, 16'h5000 | 16'($urandom_range(2047)), low_byte};
        send_access(acc, 1'b0, '0);
        acc      = '{MODE_WRITE, 16'h5800 | 16'($urandom_range(2047)), 8'hFF};
        // Break the sequence now and then: leave the counter disabled or short
        if ($urandom_range(4) == 0) acc.write_data = 8'($urandom);
        send_access(acc, 1'b0, '0);
        ticks = 254 - int'(low_byte) + $urandom_range(3);
        sent += 2;
        for (int i = 0; i < ticks; i++) begin
            acc = '{MODE_TICK, 16'($urandom), 8'($urandom)};
            if ($urandom_range(4) == 0) begin
                acc.mode    = MODE_READ;
                acc.address = 16'h5000 | 16'($urandom_range(4095));
            end
            send_access(acc, 1'b0, '0);
            sent++;
        end
    endtask

    // Check accepted results, predict accepted transactions, watch for a hang
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        bit        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (result_ch.valid && result_ch.ready) begin
                moved = 1'b1;
                got   = result_ch.payload;
                if (pending_translations.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
                    mismatch_count++;
                end else begin
                    want = pending_translations.pop_front();
                    check_field("target", int'(want.target), int'(got.target));
                    check_field("bank", int'(want.bank), int'(got.bank));
                    check_field("offset", int'(want.offset), int'(got.offset));
                    check_field("read_data", int'(want.read_data), int'(got.read_data));
                    check_field("irq_line", int'(want.irq_line), int'(got.irq_line));
                end
            end
            if (access_ch.valid && access_ch.ready) begin
                moved = 1'b1;
                want  = translate_access(access_ch.payload);
                if (typed_valid) want = typed_result;
                pending_translations.push_back(want);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // Receiver: stall at random for short and long stretches
    always @(posedge i_clk) begin : receiver
        int stall;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left--;
        end else begin
            stall = gap_len(sink_idle_pct);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                stall_left = stall - 1;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Reset, directed table, then random phases across configuration settings
    initial begin : stimulus
        logic [6:0] phase_banks [PHASE_COUNT] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd0};
        logic       phase_ram [PHASE_COUNT]   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        int         phase_idle [PHASE_COUNT]  = '{30, 0, 30, 40, 20};
        int         sent;
        bit         held;
        access_ch.valid   <= 1'b0;
        access_ch.payload <= '0;
        typed_valid       <= 1'b0;
        typed_result      <= '0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_PRG_ROM_BANKS;
        cfg_wdata         <= '0;
        i_rst_n           <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_access(directed_rows[r].access, directed_rows[r].typed,
                        directed_rows[r].result);
        end

        held = 1'b0;
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            settle();
            if (phase == PHASE_COUNT - 1) begin
                phase_banks[phase] = 7'($urandom_range(127));
                phase_ram[phase]   = 1'($urandom_range(1));
            end
            load_config(phase_banks[phase], phase_ram[phase]);
            source_idle_pct = phase_idle[phase];
            sink_idle_pct   = phase_idle[phase];
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // Hold off once mid-run until the block has drained
                if (!held && sent >= ITEMS_PER_PHASE / 2) begin
                    settle();
                    held = 1'b1;
                end
                if ($urandom_range(99) < 4) begin
                    run_irq_countdown(sent);
                end else begin
                    send_access(random_access(), 1'b0, '0);
                    sent++;
                end
            end
        end

        settle();
        if (pending_translations.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_translations.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== cartridge_bank_mapper_irq_unit.f =====
+incdir+design
design/cbm_pkg.sv
design/cbm_stream_if.sv
design/cbm_in_stage.sv
design/cbm_core.sv
design/cbm_out_stage.sv
design/cartridge_bank_mapper_irq_unit.sv
bench/tb_top.sv
